// ===== src/ptne_pkg.sv =====
// Shared types and constants for the palette text number extractor.
`default_nettype none
package ptne_pkg;

  localparam int VALUE_COUNT = 768;
  localparam int CNT_W       = $clog2(VALUE_COUNT + 1);
  localparam int IDX_W       = 10;
  localparam int SAT_LIMIT   = 255;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int QPTR_W = 1;
  localparam int QCNT_W = QPTR_W + 1;
  localparam int QDEPTH = 1 << QPTR_W;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_SLASH = 3'd2,
    CLS_CMT   = 3'd3,
    CLS_EOL   = 3'd4
  } cls_t;

  typedef enum logic [2:0] {
    LEX_NORMAL  = 3'b001,
    LEX_SLASH   = 3'b010,
    LEX_COMMENT = 3'b100
  } lex_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       eof;
  } item_t;

endpackage
`default_nettype wire

// ===== src/palette_text_number_extractor.sv =====
// Top level: palette text number extractor, one text byte per transaction.
// Each byte is written to the queue; the back end reads it and registers its result.
// Throughput: one byte per cycle; while the output is stalled the two-entry
// queue takes two more bytes before the input stalls.
// Reset: synchronous, active low; clears the lexer, accumulator, value count,
// queue pointers and output valid.
`default_nettype none
module palette_text_number_extractor (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic                      in_end_of_file,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_value,
  output logic                           out_value_valid,
  output logic [ptne_pkg::IDX_W-1:0]     out_value_index,
  output logic                           out_finished,
  output logic                           out_success
);
  import ptne_pkg::*;

  item_t wr_item, rd_item;
  logic  q_wr, q_full, q_rd, q_valid;

  assign in_stall = q_full;

  ptne_front u_front (
    .in_valid       (in_valid),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .q_full         (q_full),
    .q_item         (wr_item),
    .q_wr           (q_wr)
  );

  ptne_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_item  (wr_item),
    .full     (q_full),
    .rd_en    (q_rd),
    .rd_valid (q_valid),
    .rd_item  (rd_item)
  );

  ptne_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (rd_item),
    .q_rd            (q_rd),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_value_valid (out_value_valid),
    .out_value_index (out_value_index),
    .out_finished    (out_finished),
    .out_success     (out_success)
  );

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value_valid || out_finished))
    else $error("result with neither value nor end of file");

  a_success_needs_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_success) |-> out_finished)
    else $error("success flagged without finish");

  a_empty_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_value_valid) |-> (out_value == '0 && out_value_index == '0))
    else $error("value fields not cleared on a result without value");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value_valid) |-> (32'(out_value_index) < VALUE_COUNT))
    else $error("value index beyond value count");

endmodule
`default_nettype wire

// ===== src/ptne_front.sv =====
// Front end: classifies each incoming byte and hands it to the queue.
`default_nettype none
module ptne_front (
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_end_of_file,
  input  wire logic          q_full,
  output ptne_pkg::item_t    q_item,
  output logic               q_wr
);
  import ptne_pkg::*;

  cls_t cls;

  always_comb begin
    cls = CLS_OTHER;
    if (in_data_byte >= CH_ZERO && in_data_byte <= CH_NINE) begin
      cls = CLS_DIGIT;
    end else if (in_data_byte == CH_SLASH) begin
      cls = CLS_SLASH;
    end else if (in_data_byte == CH_HASH || in_data_byte == CH_SEMI) begin
      cls = CLS_CMT;
    end else if (in_data_byte == CH_LF || in_data_byte == CH_CR) begin
      cls = CLS_EOL;
    end
  end

  assign q_item.cls   = cls;
  assign q_item.digit = 4'(in_data_byte - CH_ZERO);
  assign q_item.eof   = in_end_of_file;
  assign q_wr         = in_valid && !q_full;

endmodule
`default_nettype wire

// ===== src/ptne_queue.sv =====
// Two-entry queue between the classifier and the parser.
`default_nettype none
module ptne_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  ptne_pkg::item_t       wr_item,
  output logic                  full,
  input  wire logic             rd_en,
  output logic                  rd_valid,
  output ptne_pkg::item_t       rd_item
);
  import ptne_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = do_wr ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/ptne_back.sv =====
// Back end: lexer state, digit accumulation and the registered result.
`default_nettype none
module ptne_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  ptne_pkg::item_t        q_item,
  output logic                   q_rd,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_value,
  output logic                   out_value_valid,
  output logic [ptne_pkg::IDX_W-1:0] out_value_index,
  output logic                   out_finished,
  output logic                   out_success
);
  import ptne_pkg::*;

  lex_t             lex_r, lex_nxt;
  logic             innum_r, innum_nxt;
  logic [8:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  logic             ov_r, ov_nxt;
  logic [7:0]       val_r, val_nxt;
  logic             vv_r, vv_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             fin_r, fin_nxt;
  logic             succ_r, succ_nxt;

  logic             fire;
  logic [12:0]      prod;
  logic [CNT_W-1:0] cnt_inc;

  assign fire = q_valid && (!ov_r || !out_stall);
  assign q_rd = fire;
  assign prod = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {9'd0, q_item.digit};

  always_comb begin
    lex_nxt   = lex_r;
    innum_nxt = innum_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    vv_nxt    = 1'b0;
    val_nxt   = '0;
    idx_nxt   = '0;
    cnt_inc   = cnt_r + CNT_W'(1);

    if (!done_r) begin
      if (innum_r && q_item.cls == CLS_DIGIT) begin
        acc_nxt = (prod > 13'(SAT_LIMIT)) ? 9'(SAT_LIMIT + 1) : prod[8:0];
      end else begin
        if (innum_r) begin
          if (!acc_r[8]) begin
            vv_nxt   = 1'b1;
            val_nxt  = acc_r[7:0];
            idx_nxt  = IDX_W'(cnt_r);
            cnt_nxt  = cnt_inc;
            done_nxt = (cnt_inc >= CNT_W'(VALUE_COUNT));
          end
          innum_nxt = 1'b0;
          acc_nxt   = '0;
        end
        if (!done_nxt) begin
          if (lex_r == LEX_COMMENT) begin
            if (q_item.cls == CLS_EOL) begin
              lex_nxt = LEX_NORMAL;
            end
          end else if (q_item.cls == CLS_SLASH) begin
            lex_nxt = (lex_r == LEX_SLASH) ? LEX_COMMENT : LEX_SLASH;
          end else if (q_item.cls == CLS_CMT) begin
            lex_nxt = LEX_COMMENT;
          end else begin
            lex_nxt = LEX_NORMAL;
            if (q_item.cls == CLS_DIGIT) begin
              innum_nxt = 1'b1;
              acc_nxt   = {5'd0, q_item.digit};
            end
          end
        end
      end
      // a run still open at end of file closes here; the earlier close cannot also fire
      if (q_item.eof && innum_nxt) begin
        if (!acc_nxt[8]) begin
          vv_nxt   = 1'b1;
          val_nxt  = acc_nxt[7:0];
          idx_nxt  = IDX_W'(cnt_nxt);
          done_nxt = (cnt_nxt + CNT_W'(1) >= CNT_W'(VALUE_COUNT));
          cnt_nxt  = cnt_nxt + CNT_W'(1);
        end
        innum_nxt = 1'b0;
        acc_nxt   = '0;
      end
    end

    ov_nxt   = vv_nxt || q_item.eof;
    fin_nxt  = q_item.eof;
    succ_nxt = q_item.eof && done_nxt;

    if (q_item.eof) begin
      lex_nxt   = LEX_NORMAL;
      innum_nxt = 1'b0;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r   <= LEX_NORMAL;
      innum_r <= 1'b0;
      acc_r   <= '0;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else if (fire) begin
      lex_r   <= lex_nxt;
      innum_r <= innum_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      ov_r    <= ov_nxt;
    end else if (!out_stall) begin
      ov_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      val_r  <= val_nxt;
      vv_r   <= vv_nxt;
      idx_r  <= idx_nxt;
      fin_r  <= fin_nxt;
      succ_r <= succ_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_value       = val_r;
  assign out_value_valid = vv_r;
  assign out_value_index = idx_r;
  assign out_finished    = fin_r;
  assign out_success     = succ_r;

endmodule
`default_nettype wire

// ===== sim/tb_palette_text_number_extractor.sv =====
// Testbench for the palette text number extractor: directed table, then random palette files.
`timescale 1ns / 100ps
module tb_palette_text_number_extractor;
  import ptne_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 200;

  typedef struct packed {
    logic [7:0]       value;
    logic             value_valid;
    logic [IDX_W-1:0] value_index;
    logic             finished;
    logic             success;
  } palette_res_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_RESULT} row_kind_t;

  typedef struct {
    logic [7:0]   ch;
    logic         eof;
    row_kind_t    kind;
    palette_res_t res;
  } text_row_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte = 8'h00;
  logic             in_end_of_file = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_value;
  logic             out_value_valid;
  logic [IDX_W-1:0] out_value_index;
  logic             out_finished;
  logic             out_success;

  // parser state mirrored by the predictor
  lex_t lex_st = LEX_NORMAL;
  logic num_open = 1'b0;
  int   run_val = 0;
  int   n_found = 0;
  logic parse_done = 1'b0;

  palette_res_t expected_q[$];
  text_row_t    dir_rows[$];
  logic [7:0]   text_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int err_count = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int results_seen = 0;
  int values_seen = 0;
  int files_ok = 0;

  palette_text_number_extractor DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_file  (in_end_of_file),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_value_valid (out_value_valid),
    .out_value_index (out_value_index),
    .out_finished    (out_finished),
    .out_success     (out_success)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_parse();
    lex_st = LEX_NORMAL;
    num_open = 1'b0;
    run_val = 0;
    n_found = 0;
    parse_done = 1'b0;
  endfunction

  // Ends the open digit run; fills in the value fields when it is emitted.
  function automatic logic close_run(inout palette_res_t r);
    logic emit;
    emit = num_open && run_val <= SAT_LIMIT && !parse_done;
    if (emit) begin
      r.value = 8'(run_val);
      r.value_valid = 1'b1;
      r.value_index = IDX_W'(n_found);
      n_found++;
      if (n_found >= VALUE_COUNT) parse_done = 1'b1;
    end
    num_open = 1'b0;
    run_val = 0;
    return emit;
  endfunction

  function automatic logic predict_text(input logic [7:0] c, input logic eof,
                                        output palette_res_t r);
    logic emitted;
    emitted = 1'b0;
    r = '0;
    if (!parse_done) begin
      if (num_open && is_digit(c)) begin
        run_val = run_val * 10 + int'(c - CH_ZERO);
        if (run_val > SAT_LIMIT) run_val = SAT_LIMIT + 1;
      end else begin
        if (num_open) emitted = close_run(r);
        if (!parse_done) begin
          if (lex_st == LEX_COMMENT) begin
            if (c == CH_LF || c == CH_CR) lex_st = LEX_NORMAL;
          end else if (c == CH_SLASH) begin
            lex_st = (lex_st == LEX_SLASH) ? LEX_COMMENT : LEX_SLASH;
          end else if (c == CH_HASH || c == CH_SEMI) begin
            lex_st = LEX_COMMENT;
          end else begin
            lex_st = LEX_NORMAL;
            if (is_digit(c)) begin
              num_open = 1'b1;
              run_val = int'(c - CH_ZERO);
            end
          end
        end
      end
      // a run cut short by end of file shares the outcome transaction
      if (eof && num_open) emitted = close_run(r) || emitted;
    end
    r.finished = eof;
    r.success = eof && parse_done;
    if (eof) clear_parse();
    return emitted || eof;
  endfunction

  function automatic void add_row(input logic [7:0] c, input logic eof,
                                  input row_kind_t kind = ROW_PREDICT,
                                  input palette_res_t res = '0);
    text_row_t row;
    row.ch = c;
    row.eof = eof;
    row.kind = kind;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Appends one number; returns 0 when it is out of range and will be dropped.
  function automatic logic add_number(input int multi_pct, input int bad_pct);
    int    n;
    string s;
    if ($urandom_range(99) < bad_pct) begin
      n = ($urandom_range(3) == 0) ? 256 : $urandom_range(99999, 256);
      s = $sformatf("%0d", n);
      if ($urandom_range(3) == 0) s = {s, "0000000"};
      push_str(s);
      return 1'b0;
    end
    n = ($urandom_range(99) < multi_pct) ? $urandom_range(255) : $urandom_range(9);
    if ($urandom_range(19) == 0) n = 255;
    s = $sformatf("%0d", n);
    if ($urandom_range(15) == 0) s = {"00", s};
    push_str(s);
    return 1'b1;
  endfunction

  function automatic void add_sep(input int cmt_pct);
    string seps;
    string body;
    int    k;
    seps = " ,\t[](){}:\n\r";
    body = "0123456789 ,[]/#;x";
    k = $urandom_range(99);
    if (k < cmt_pct) begin
      case ($urandom_range(2))
        0:       text_q.push_back(CH_HASH);
        1:       text_q.push_back(CH_SEMI);
        default: push_str("//");
      endcase
      repeat ($urandom_range(8)) text_q.push_back(body[$urandom_range(body.len() - 1)]);
      text_q.push_back($urandom_range(1) ? CH_LF : CH_CR);
    end else begin
      // lone slash, ignored before an ordinary separator
      if (k < cmt_pct + 5) text_q.push_back(CH_SLASH);
      text_q.push_back(seps[$urandom_range(seps.len() - 1)]);
    end
  endfunction

  function automatic void build_short_file();
    string pool;
    int    kind;
    pool = "0123456789//#;\n\r ,[]";
    kind = $urandom_range(9);
    if (kind < 6) begin
      repeat ($urandom_range(12)) begin
        void'(add_number(50, 15));
        add_sep(25);
      end
      if ($urandom_range(1)) void'(add_number(50, 15));
      if (text_q.size() == 0) add_sep(0);
    end else if (kind < 8) begin
      repeat ($urandom_range(40, 1)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(40, 1)) text_q.push_back(pool[$urandom_range(pool.len() - 1)]);
    end
  endfunction

  // Dense palette around the value count; sometimes one short, sometimes over.
  function automatic void build_full_file();
    int goal;
    int got;
    goal = $urandom_range(VALUE_COUNT + 3, VALUE_COUNT - 1);
    got = 0;
    while (got < goal) begin
      if (add_number(2, 0)) got++;
      if (got < goal || $urandom_range(1)) add_sep(0);
    end
    if ($urandom_range(1))
      repeat ($urandom_range(20, 1)) text_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void pick_idle();
    idle_pct  = ($urandom_range(2) == 0) ? 0 : $urandom_range(70, 5);
    stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(70, 5);
  endfunction

  task automatic send_item(input logic [7:0] c, input logic eof);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= c;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (eof) files_sent++;
  endtask

  task automatic send_text(input logic [7:0] c, input logic eof);
    palette_res_t r;
    send_item(c, eof);
    if (predict_text(c, eof, r)) expected_q.push_back(r);
  endtask

  task automatic send_file();
    foreach (text_q[i]) send_text(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // Receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    palette_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_value_valid) values_seen++;
        if (out_finished && out_success) files_ok++;
        if (expected_q.size() == 0) begin
          $error("unexpected result: value %0d index %0d finished %0b",
                 out_value, out_value_index, out_finished);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("value", want.value, out_value);
          compare_field("value_valid", want.value_valid, out_value_valid);
          compare_field("value_index", want.value_index, out_value_index);
          compare_field("finished", want.finished, out_finished);
          compare_field("success", want.success, out_success);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $error("no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_q.size());
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin
    palette_res_t r;
    logic         has_res;
    int           rand_start;

    // run to 255, overlong run past 256, lone slash, comment forms, brackets, end of file
    add_row("2", 1'b0);
    add_row("5", 1'b0);
    add_row("5", 1'b0);
    add_row(" ", 1'b0, ROW_RESULT, palette_res_t'{8'd255, 1'b1, 10'd0, 1'b0, 1'b0});
    add_row("2", 1'b0);
    add_row("5", 1'b0);
    add_row("6", 1'b0);
    add_row("0", 1'b0);
    add_row(8'hFF, 1'b0, ROW_SILENT);
    add_row("/", 1'b0);
    add_row("1", 1'b0);
    add_row("/", 1'b0, ROW_RESULT, palette_res_t'{8'd1, 1'b1, 10'd1, 1'b0, 1'b0});
    add_row("/", 1'b0, ROW_SILENT);
    add_row("7", 1'b0, ROW_SILENT);
    add_row(CH_CR, 1'b0, ROW_SILENT);
    add_row(CH_SEMI, 1'b0, ROW_SILENT);
    add_row("5", 1'b0, ROW_SILENT);
    add_row(CH_LF, 1'b0, ROW_SILENT);
    add_row(CH_HASH, 1'b0, ROW_SILENT);
    add_row(CH_CR, 1'b0, ROW_SILENT);
    add_row("[", 1'b0);
    add_row("0", 1'b0);
    add_row("]", 1'b0, ROW_RESULT, palette_res_t'{8'd0, 1'b1, 10'd2, 1'b0, 1'b0});
    add_row("4", 1'b0);
    add_row("2", 1'b1, ROW_RESULT, palette_res_t'{8'd42, 1'b1, 10'd3, 1'b1, 1'b0});
    add_row(8'h00, 1'b1, ROW_RESULT, palette_res_t'{8'd0, 1'b0, 10'd0, 1'b1, 1'b0});

    idle_pct = 30;
    stall_pct = 30;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].ch, dir_rows[i].eof);
      has_res = predict_text(dir_rows[i].ch, dir_rows[i].eof, r);
      if (dir_rows[i].kind == ROW_RESULT) expected_q.push_back(dir_rows[i].res);
      else if (dir_rows[i].kind == ROW_PREDICT && has_res) expected_q.push_back(r);
    end
    drain();

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      pick_idle();
      build_short_file();
      send_file();
      if ($urandom_range(5) == 0) drain();
    end

    // closing stretch at full rate; no new stall burst starts, though one already running may outlast the drain
    idle_pct = 0;
    stall_pct = 0;
    drain();
    build_full_file();
    send_file();

    drain();
    repeat (10) @(posedge clk);

    $display("%0d bytes over %0d files (%0d from the directed table), %0d results checked",
             bytes_sent, files_sent, dir_rows.size(), results_seen);
    $display("%0d values extracted, %0d files reached the full palette",
             values_seen, files_ok);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== palette_text_number_extractor.f =====
src/ptne_pkg.sv
src/ptne_front.sv
src/ptne_queue.sv
src/ptne_back.sv
src/palette_text_number_extractor.sv
sim/tb_palette_text_number_extractor.sv
